// ----- design/lrupr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_pkg
// Types and constants shared by the LRU page replacement unit.
// ----------------------------------------------------------------------------
package lrupr_pkg;

	localparam int PAGE_BITS = 16;
	localparam int SLOT_W    = 3;
	localparam int FAULT_W   = 16;
	localparam int CFG_W     = 4;

	localparam logic [FAULT_W-1:0] FAULT_MAX    = '1;
	localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd8;

	typedef struct packed {
		logic                 first_of_sequence;
		logic [PAGE_BITS-1:0] page_number;
	} ref_item_t;

	typedef struct packed {
		logic                 hit;
		logic [SLOT_W-1:0]    slot;
		logic                 evicted_valid;
		logic [PAGE_BITS-1:0] evicted_page;
		logic [FAULT_W-1:0]   fault_total;
	} res_item_t;

	typedef enum logic [1:0] {
		ORD_HOLD,
		ORD_TOUCH,
		ORD_APPEND
	} order_op_t;

endpackage

// ----- design/lru_page_replacement_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// LRU page replacement over a set of frames, one page reference per item.
// ----------------------------------------------------------------------------
// Usage:
//   ref channel (ref_valid / ref_stall / ref_item) carries one page reference
//   per item; an item with first_of_sequence set clears frames, recency order
//   and fault count first and latches frames_in_use.
//   res channel (res_valid / res_stall / res_item) returns one result per
//   reference: hit, frame slot, evicted page and fault count.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes frames_in_use; it is
//   always ready and the value applies at the next sequence start.
// An accepted item passes through the input register, then the lookup and
// recency update in a single pass into the result register.
// Throughput is one item per cycle while the receiver does not stall; each
// reference reads back the frame table and recency list updated before it.
// Reset clears all frames and counters and selects eight frames (capped at
// MAX_FRAMES). While the receiver stalls a full result register, the input
// register holds its item and ref_stall rises once both are occupied.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit #(
	parameter int MAX_FRAMES = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            ref_valid,
	output logic                            ref_stall,
	input  lrupr_pkg::ref_item_t            ref_item,
	output logic                            res_valid,
	input  logic                            res_stall,
	output lrupr_pkg::res_item_t            res_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lrupr_pkg::CFG_W-1:0]     cfg_data
);
	import lrupr_pkg::*;

	localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW = $clog2(MAX_FRAMES + 1);

	function automatic logic [CW-1:0] clamp_frames(input logic [CFG_W-1:0] v);
		logic [CW-1:0] r;
		if (v == '0) begin
			r = CW'(1);
		end else if (int'(v) > MAX_FRAMES) begin
			r = CW'(MAX_FRAMES);
		end else begin
			r = CW'(v);
		end
		return r;
	endfunction

	logic [CFG_W-1:0]     frames_in_use_q;
	logic [CW-1:0]        active_q;
	logic [CW-1:0]        count_q;
	logic [FAULT_W-1:0]   faults_q;
	logic [MAX_FRAMES-1:0] valid_q;
	logic [PAGE_BITS-1:0] page_q [MAX_FRAMES];

	logic      item_valid_s1;
	ref_item_t item_s1;
	logic      res_valid_q;
	res_item_t res_q;

	logic advance;
	logic step;

	logic                  fos;
	logic [MAX_FRAMES-1:0] valid_eff;
	logic [MAX_FRAMES-1:0] valid_nxt;
	logic [CW-1:0]         count_eff;
	logic [CW-1:0]         active_eff;
	logic [FAULT_W-1:0]    faults_eff;
	logic [FAULT_W-1:0]    faults_nxt;
	logic                  hit;
	logic [FW-1:0]         hit_idx;
	logic [FW-1:0]         free_idx;
	logic [FW-1:0]         lru_slot;
	logic                  full;
	order_op_t             op;
	logic [FW-1:0]         slot_sel;
	logic                  evict;
	logic [PAGE_BITS-1:0]  evicted_page;

	assign cfg_ready = 1'b1;
	assign advance   = !res_valid_q || !res_stall;
	assign ref_stall = item_valid_s1 && !advance;
	assign step      = item_valid_s1 && advance;

	// sequence start sees a cleared table
	assign fos        = item_s1.first_of_sequence;
	assign valid_eff  = fos ? '0 : valid_q;
	assign count_eff  = fos ? '0 : count_q;
	assign faults_eff = fos ? '0 : faults_q;
	assign active_eff = fos ? clamp_frames(frames_in_use_q) : active_q;
	assign full       = (count_eff == active_eff);

	lrupr_lookup #(
		.MAX_FRAMES(MAX_FRAMES)
	) u_lookup (
		.page        (item_s1.page_number),
		.frame_page  (page_q),
		.frame_valid (valid_eff),
		.active      (active_eff),
		.hit         (hit),
		.hit_idx     (hit_idx),
		.free_idx    (free_idx)
	);

	always_comb begin
		op       = ORD_HOLD;
		slot_sel = hit_idx;
		evict    = 1'b0;
		if (hit) begin
			op       = ORD_TOUCH;
			slot_sel = hit_idx;
		end else if (!full) begin
			op       = ORD_APPEND;
			slot_sel = free_idx;
		end else begin
			op       = ORD_TOUCH;
			slot_sel = lru_slot;
			evict    = 1'b1;
		end
		if (!step) begin
			op = ORD_HOLD;
		end
	end

	lrupr_order #(
		.MAX_FRAMES(MAX_FRAMES)
	) u_order (
		.clk      (clk),
		.op       (op),
		.slot     (slot_sel),
		.used     (count_eff),
		.lru_slot (lru_slot)
	);

	// mark the filled frame on a fault
	always_comb begin
		valid_nxt = valid_eff;
		if (!hit) begin
			valid_nxt[slot_sel] = 1'b1;
		end
	end

	assign evicted_page = evict ? page_q[slot_sel] : '0;
	assign faults_nxt   = (hit || faults_eff == FAULT_MAX) ? faults_eff
	                                                       : faults_eff + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= FRAMES_RESET;
			active_q        <= clamp_frames(FRAMES_RESET);
			count_q         <= '0;
			faults_q        <= '0;
			valid_q         <= '0;
			item_valid_s1   <= 1'b0;
			res_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				frames_in_use_q <= cfg_data;
			end
			if (!ref_stall) begin
				item_valid_s1 <= ref_valid;
			end
			if (advance) begin
				res_valid_q <= item_valid_s1;
			end
			if (step) begin
				active_q <= active_eff;
				faults_q <= faults_nxt;
				valid_q  <= valid_nxt;
				count_q  <= (op == ORD_APPEND) ? count_eff + 1'b1 : count_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ref_valid && !ref_stall) begin
			item_s1 <= ref_item;
		end
		if (step) begin
			if (!hit) begin
				page_q[slot_sel] <= item_s1.page_number;
			end
			res_q.hit           <= hit;
			res_q.slot          <= SLOT_W'(slot_sel);
			res_q.evicted_valid <= evict;
			res_q.evicted_page  <= evicted_page;
			res_q.fault_total   <= faults_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

endmodule

// ----- design/lrupr_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_lookup
// Parallel compare of a page against all frames, plus first free frame search.
// ----------------------------------------------------------------------------
module lrupr_lookup #(
	parameter int MAX_FRAMES = 8,
	parameter int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
	parameter int CW = $clog2(MAX_FRAMES + 1)
) (
	input  logic [lrupr_pkg::PAGE_BITS-1:0] page,
	input  logic [lrupr_pkg::PAGE_BITS-1:0] frame_page [MAX_FRAMES],
	input  logic [MAX_FRAMES-1:0]           frame_valid,
	input  logic [CW-1:0]                   active,
	output logic                            hit,
	output logic [FW-1:0]                   hit_idx,
	output logic [FW-1:0]                   free_idx
);
	import lrupr_pkg::*;

	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		// scan from the top so the lowest index wins
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (frame_valid[i] && frame_page[i] == page) begin
				hit     = 1'b1;
				hit_idx = FW'(i);
			end
			if (!frame_valid[i] && i < int'(active)) begin
				free_idx = FW'(i);
			end
		end
	end

endmodule

// ----- design/lrupr_order.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_order
// Recency list of frame indices, least recent at position zero.
// ----------------------------------------------------------------------------
module lrupr_order #(
	parameter int MAX_FRAMES = 8,
	parameter int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
	parameter int CW = $clog2(MAX_FRAMES + 1)
) (
	input  logic                  clk,
	input  lrupr_pkg::order_op_t  op,
	input  logic [FW-1:0]         slot,
	input  logic [CW-1:0]         used,
	output logic [FW-1:0]         lru_slot
);
	import lrupr_pkg::*;

	logic [FW-1:0]         order_q [MAX_FRAMES];
	logic [FW-1:0]         order_d [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] match;
	logic [MAX_FRAMES-1:0] at_or_after;

	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			match[i] = (i < int'(used)) && (order_q[i] == slot);
		end
		for (int i = 0; i < MAX_FRAMES; i++) begin
			at_or_after[i] = 1'b0;
			for (int j = 0; j <= i; j++) begin
				at_or_after[i] = at_or_after[i] | match[j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			order_d[i] = order_q[i];
		end
		case (op)
			ORD_TOUCH: begin
				// close the gap at the touched entry, put it at the recent end
				for (int i = 0; i < MAX_FRAMES; i++) begin
					if (i + 1 == int'(used)) begin
						order_d[i] = slot;
					end else if (i + 1 < int'(used) && at_or_after[i]) begin
						if (i < MAX_FRAMES - 1) begin
							order_d[i] = order_q[i + 1];
						end
					end
				end
			end
			ORD_APPEND: begin
				for (int i = 0; i < MAX_FRAMES; i++) begin
					if (i == int'(used)) begin
						order_d[i] = slot;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			order_q[i] <= order_d[i];
		end
	end

	assign lru_slot = order_q[0];

endmodule

// ----- design/lrupr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_checker
// Port-level checks for the LRU page replacement unit, bound to the top level.
// ----------------------------------------------------------------------------
module lrupr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        ref_valid,
	input logic                        ref_stall,
	input lrupr_pkg::ref_item_t        ref_item,
	input logic                        res_valid,
	input logic                        res_stall,
	input lrupr_pkg::res_item_t        res_item,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic [lrupr_pkg::CFG_W-1:0] cfg_data
);
	import lrupr_pkg::*;

	// hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("stalled result changed");

	// input backs up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		ref_stall |-> res_valid && res_stall)
		else $error("input stalled without a stalled result");

	// a fresh result traces back to an accepted item
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(ref_valid && !ref_stall, 2))
		else $error("result without an accepted item");

	// a hit never reports an eviction
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.hit |-> !res_item.evicted_valid && res_item.evicted_page == '0)
		else $error("hit reported an evicted page");

endmodule

bind lru_page_replacement_unit lrupr_checker u_lrupr_checker (.*);

// ----- sim/lru_page_replacement_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_unit_tb
// Self-checking bench for the LRU page replacement unit. A scoreboard keeps
// its own frame table, recency list and fault counter. It predicts hit, slot,
// eviction and fault count for every accepted reference and checks each
// returned result in order. Stimulus covers these cases:
//   - directed references: page extremes, the latched frame count, frame
//     counts of zero and above eight, and a one-frame run where every
//     reference faults
//   - random sequences drawn from small working sets, with bursty input
//     and a receiver that stalls in several patterns
//   - one long receiver hold-off that backs the block up
// ----------------------------------------------------------------------------
module lru_page_replacement_unit_tb;
	import lrupr_pkg::*;

	localparam int FRAME_CNT   = 8;
	localparam int HOLD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_RANDOM,
		RX_PERIODIC
	} rx_mode_t;

	class lru_ref_scoreboard;
		logic [PAGE_BITS-1:0] frame_pg  [FRAME_CNT];
		bit                   frame_vld [FRAME_CNT];
		logic [SLOT_W-1:0]    lru_order [FRAME_CNT];
		int unsigned          resident;
		logic [FAULT_W-1:0]   faults;
		logic [CFG_W-1:0]     frames_reg;
		int unsigned          active;
		res_item_t            expected_q [$];
		int unsigned          mismatches, refs, hits, evictions, restarts, saturated;

		function new();
			clear_frames();
			frames_reg = FRAMES_RESET;
			active     = frames_for(frames_reg);
		endfunction

		function int unsigned frames_for(logic [CFG_W-1:0] v);
			if (v == 0) begin
				return 1;
			end
			if (v > FRAME_CNT) begin
				return FRAME_CNT;
			end
			return int'(v);
		endfunction

		function void clear_frames();
			for (int i = 0; i < FRAME_CNT; i++) begin
				frame_pg[i]  = '0;
				frame_vld[i] = 1'b0;
				lru_order[i] = '0;
			end
			resident = 0;
			faults   = '0;
		endfunction

		function void write_frames(logic [CFG_W-1:0] v);
			frames_reg = v;
		endfunction

		// move the entry at pos to the most-recent end of the used part
		function void promote(int unsigned pos);
			logic [SLOT_W-1:0] f;
			f = lru_order[pos];
			for (int unsigned i = pos; i + 1 < resident; i++) begin
				lru_order[i] = lru_order[i + 1];
			end
			lru_order[resident - 1] = f;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void note_reference(ref_item_t it);
			res_item_t   exp_res;
			int          found;
			int unsigned target;
			exp_res = '0;
			found   = -1;
			target  = 0;
			refs++;
			if (it.first_of_sequence) begin
				clear_frames();
				active = frames_for(frames_reg);
				restarts++;
			end
			for (int i = 0; i < active; i++) begin
				if (found < 0 && frame_vld[i] && frame_pg[i] == it.page_number) begin
					found = i;
				end
			end
			if (found >= 0) begin
				exp_res.hit  = 1'b1;
				exp_res.slot = SLOT_W'(found);
				for (int unsigned i = 0; i < resident; i++) begin
					if (lru_order[i] == SLOT_W'(found)) begin
						promote(i);
						break;
					end
				end
				hits++;
			end else begin
				if (resident < active) begin
					for (int i = 0; i < active; i++) begin
						if (!frame_vld[i]) begin
							target = i;
							break;
						end
					end
					lru_order[resident] = SLOT_W'(target);
					resident++;
				end else begin
					target                = lru_order[0];
					exp_res.evicted_valid = 1'b1;
					exp_res.evicted_page  = frame_pg[target];
					promote(0);
					evictions++;
				end
				exp_res.slot      = SLOT_W'(target);
				frame_pg[target]  = it.page_number;
				frame_vld[target] = 1'b1;
				if (faults != FAULT_MAX) begin
					faults++;
				end
			end
			exp_res.fault_total = faults;
			if (faults == FAULT_MAX) begin
				saturated++;
			end
			expected_q.push_back(exp_res);
		endfunction

		function void check_result(res_item_t got);
			res_item_t exp_res;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: result with no reference outstanding: hit=%0b slot=%0d",
						$time, got.hit, got.slot);
				end
				return;
			end
			exp_res = expected_q.pop_front();
			if (got.hit !== exp_res.hit || got.slot !== exp_res.slot
					|| got.evicted_valid !== exp_res.evicted_valid
					|| got.evicted_page !== exp_res.evicted_page
					|| got.fault_total !== exp_res.fault_total) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: mismatch, expected hit=%0b slot=%0d evict=%0b/%h faults=%0d",
						$time, exp_res.hit, exp_res.slot, exp_res.evicted_valid,
						exp_res.evicted_page, exp_res.fault_total);
					$display("%0t:           actual   hit=%0b slot=%0d evict=%0b/%h faults=%0d",
						$time, got.hit, got.slot, got.evicted_valid,
						got.evicted_page, got.fault_total);
				end
			end
		endfunction
	endclass

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             ref_valid = 1'b0;
	logic             ref_stall;
	ref_item_t        ref_item  = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	res_item_t        res_item;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data  = '0;

	lru_ref_scoreboard sb = new();

	rx_mode_t    rx_mode      = RX_FREE;
	bit          hold_off_req = 1'b0;
	bit          gaps_on      = 1'b0;
	int unsigned burst_left   = 0;
	int unsigned gap_len;
	int unsigned rx_tick      = 0;
	int unsigned cycles       = 0;
	int unsigned in_stalls    = 0;
	int unsigned cfg_writes   = 0;
	int unsigned hold_offs    = 0;
	int unsigned pool_base, pool_size;
	logic [CFG_W-1:0] cfg_val;
	bit          fos;
	logic [PAGE_BITS-1:0] page;

	lru_page_replacement_unit #(
		.MAX_FRAMES(FRAME_CNT)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.ref_valid(ref_valid),
		.ref_stall(ref_stall),
		.ref_item (ref_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("lru_page_replacement_unit_tb: done, errors");
			$finish;
		end
	end

	// sample every handshake at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.write_frames(cfg_data);
				cfg_writes++;
			end
			if (ref_valid && ref_stall) begin
				in_stalls++;
			end
			if (ref_valid && !ref_stall) begin
				sb.note_reference(ref_item);
			end
			if (res_valid && !res_stall) begin
				sb.check_result(res_item);
			end
		end
	end

	// receiver: stall pattern per mode, plus one long hold-off on request
	always begin
		@(negedge clk);
		if (hold_off_req) begin
			hold_off_req = 1'b0;
			res_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_offs++;
		end
		rx_tick++;
		case (rx_mode)
			RX_RANDOM:   res_stall <= ($urandom_range(0, 2) == 0);
			RX_PERIODIC: res_stall <= ((rx_tick % 5) < 2);
			default:     res_stall <= 1'b0;
		endcase
	end

	// offer one reference and hold it until accepted; bursts end in a gap when gaps are on
	task automatic send_ref(input bit first, input logic [PAGE_BITS-1:0] pg);
		ref_valid                  <= 1'b1;
		ref_item.first_of_sequence <= first;
		ref_item.page_number       <= pg;
		@(posedge clk);
		while (ref_stall) @(posedge clk);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap_len    = gaps_on ? $urandom_range(1, 6) : 0;
			if (gap_len > 0) begin
				ref_valid <= 1'b0;
				repeat (gap_len) @(negedge clk);
			end
		end
	endtask

	// drop valid and wait until every result is back
	task automatic settle();
		ref_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// no sequence start yet: the frame count from reset applies
		send_ref(1'b0, 16'h0000);
		send_ref(1'b0, 16'hFFFF);
		send_ref(1'b0, 16'h0000);
		send_ref(1'b0, 16'hFFFF);

		// frame count of zero acts as one frame
		settle();
		write_frames(4'd0);
		send_ref(1'b1, 16'h1234);
		send_ref(1'b0, 16'h1234);
		send_ref(1'b0, 16'hABCD);
		send_ref(1'b0, 16'h1234);

		// oversized frame count caps at eight; fill, evict, hit, then evict again
		settle();
		write_frames(4'd15);
		send_ref(1'b1, 16'd1);
		for (int p = 2; p <= 8; p++) begin
			send_ref(1'b0, PAGE_BITS'(p));
		end
		send_ref(1'b0, 16'd9);
		send_ref(1'b0, 16'd2);
		send_ref(1'b0, 16'd10);
		send_ref(1'b0, 16'd1);

		// new count waits for the next sequence start
		settle();
		write_frames(4'd3);
		send_ref(1'b0, 16'd9);
		send_ref(1'b1, 16'd7);

		// one frame, every reference a fault and every one after the first an eviction
		settle();
		write_frames(4'd1);
		send_ref(1'b1, 16'd0);
		for (int p = 1; p <= 20; p++) begin
			send_ref(1'b0, PAGE_BITS'(p));
		end

		for (int ph = 0; ph < 12; ph++) begin
			settle();
			case (ph)
				0:       cfg_val = 4'd0;
				1:       cfg_val = 4'd15;
				2:       cfg_val = 4'd1;
				3:       cfg_val = 4'd8;
				default: cfg_val = CFG_W'($urandom_range(0, 15));
			endcase
			write_frames(cfg_val);
			rx_mode = rx_mode_t'(ph % 3);
			gaps_on = (ph % 4) != 1;
			if (ph == 4) begin
				// keep offering while the receiver holds off
				gaps_on      = 1'b0;
				rx_mode      = RX_FREE;
				hold_off_req = 1'b1;
			end
			pool_base = $urandom_range(0, 65535);
			pool_size = $urandom_range(1, 12);
			for (int n = 0; n < 116; n++) begin
				fos = (n == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
				if (fos) begin
					pool_base = $urandom_range(0, 65535);
					pool_size = $urandom_range(1, 12);
				end
				if ($urandom_range(0, 99) < 85) begin
					page = PAGE_BITS'(pool_base + $urandom_range(0, pool_size - 1));
				end else begin
					page = PAGE_BITS'($urandom_range(0, 65535));
				end
				send_ref(fos, page);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("summary: %0d references, %0d sequence starts, %0d hits, %0d evictions",
			sb.refs, sb.restarts, sb.hits, sb.evictions);
		$display("summary: %0d input stall cycles, %0d frame writes, %0d hold-offs",
			in_stalls, cfg_writes, hold_offs);
		if (sb.mismatches == 0) begin
			$display("lru_page_replacement_unit_tb: done, clean");
		end else begin
			$display("lru_page_replacement_unit_tb: done, errors");
		end
		$finish;
	end

endmodule
